// ----- rtl/cctu_pkg.sv -----
package cctu_pkg;

    // field widths
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned COUNT_W  = 64;
    localparam int unsigned HZ_W     = 30;
    localparam int unsigned SEC_W    = 45;
    localparam int unsigned NS_W     = 30;
    localparam int unsigned PROD_W   = 60;
    localparam int unsigned STEP_W   = 7;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    // clock kinds
    localparam logic [KIND_W-1:0] KIND_MONOTONIC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REALTIME  = 2'd1;

    // status codes
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_CLOCK_HZ = 1'b0;

    localparam logic [HZ_W-1:0]   HZ_RESET   = 30'd156000000;
    localparam logic [NS_W-1:0]   NS_PER_SEC = 30'd1000000000;
    localparam logic [STEP_W-1:0] SEC_STEPS  = 7'd64;
    localparam logic [STEP_W-1:0] NS_STEPS   = 7'd60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SEC,
        ST_MUL,
        ST_DIV_NS,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ----- rtl/cctu_div.sv -----
module cctu_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cctu_pkg::t_div_ctl            i_ctl,
    input  logic [cctu_pkg::COUNT_W-1:0]  i_dividend,
    input  logic [cctu_pkg::HZ_W-1:0]     i_divisor,
    output cctu_pkg::t_div_sts            o_sts,
    output logic [cctu_pkg::COUNT_W-1:0]  o_quot,
    output logic [cctu_pkg::HZ_W-1:0]     o_rem
);
    import cctu_pkg::*;

    // restoring divider, one quotient bit per cycle; quotient shifts in
    // at the bottom as the dividend shifts out at the top
    logic [COUNT_W-1:0] r_shift;
    logic [HZ_W-1:0]    r_rem;
    logic [HZ_W-1:0]    r_divisor;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [HZ_W+1:0] diff;
    logic            ge;
    logic [HZ_W-1:0] rem_next;

    always_comb begin
        diff     = {1'b0, r_rem, r_shift[COUNT_W-1]} - {2'b00, r_divisor};
        ge       = ~diff[HZ_W+1];
        rem_next = ge ? diff[HZ_W-1:0] : {r_rem[HZ_W-2:0], r_shift[COUNT_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_ctl.steps;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != 7'd1);
            r_done <= (r_cnt == 7'd1);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_shift   <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[COUNT_W-2:0], ge};
            r_rem   <= rem_next;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_shift;
    assign o_rem      = r_rem;

endmodule

// ----- rtl/cycle_count_to_timespec_unit.sv -----
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_ready   i_clock_kind, i_counter_sample
// result    out        o_valid / i_ready   o_status, o_seconds, o_nanoseconds
// config    in         APB (psel/penable)  paddr, pwdata -> clock_hz; prdata reads back
//
// One request at a time. A supported request runs 64 divider steps for the seconds, then
// the product remainder * 1e9 and the divider restart, then 60 steps for the nanoseconds,
// the move to result and the output load.
// An unsupported clock kind goes straight to result and the output load, state unchanged.
// Synchronous active-low reset: clock_hz to 156 MHz, wrap count and previous sample to 0.
// A stalled result holds the sequencer in result and o_ready low.
module cycle_count_to_timespec_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [cctu_pkg::KIND_W-1:0]    i_clock_kind,
    input  logic [cctu_pkg::SAMPLE_W-1:0]  i_counter_sample,
    // result
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_status,
    output logic [cctu_pkg::SEC_W-1:0]     o_seconds,
    output logic [cctu_pkg::NS_W-1:0]      o_nanoseconds,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cctu_pkg::ADDR_W-1:0]    paddr,
    input  logic [cctu_pkg::DATA_W-1:0]    pwdata,
    output logic [cctu_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import cctu_pkg::*;

    // --- configuration register -------------------------------------
    logic [HZ_W-1:0] r_hz;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_CLOCK_HZ);
    assign prdata = (paddr[2] == REG_CLOCK_HZ) ? {2'b00, r_hz} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hz <= HZ_RESET;
        end else if (cfg_wr) begin
            r_hz <= pwdata[HZ_W-1:0];
        end
    end

    // --- counter extension state ------------------------------------
    logic [SAMPLE_W-1:0] r_wrap;
    logic [SAMPLE_W-1:0] r_prev;
    logic [SAMPLE_W-1:0] n_wrap;
    logic                in_xfer;
    logic                kind_ok;
    logic [HZ_W-1:0]     hz_eff;

    assign in_xfer = i_valid & o_ready;
    assign kind_ok = (i_clock_kind == KIND_MONOTONIC) || (i_clock_kind == KIND_REALTIME);
    // a sample below the previous one means the counter wrapped once
    assign n_wrap  = (i_counter_sample < r_prev) ? r_wrap + 1'b1 : r_wrap;
    // zero frequency behaves as 1 Hz
    assign hz_eff  = (r_hz == '0) ? {{(HZ_W-1){1'b0}}, 1'b1} : r_hz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= '0;
            r_prev <= '0;
        end else if (in_xfer && kind_ok) begin
            r_wrap <= n_wrap;
            r_prev <= i_counter_sample;
        end
    end

    // --- shared serial divider --------------------------------------
    t_div_ctl           div_ctl;
    t_div_sts           div_sts;
    logic [COUNT_W-1:0] div_dividend;
    logic [COUNT_W-1:0] div_quot;
    logic [HZ_W-1:0]    div_rem;

    cctu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (hz_eff),
        .o_sts      (div_sts),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // --- sequencer --------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic              r_err;
    logic [SEC_W-1:0]  r_secs;
    logic [PROD_W-1:0] r_prod;
    logic              cap_secs;
    logic              load_out;
    logic              out_free;

    assign out_free = ~o_valid | i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = kind_ok ? ST_DIV_SEC : ST_RESULT;
                end
            end
            ST_DIV_SEC: begin
                if (div_sts.done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV_NS;
            end
            ST_DIV_NS: begin
                if (div_sts.done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready       = 1'b0;
        div_ctl.start = 1'b0;
        div_ctl.steps = SEC_STEPS;
        div_dividend  = {n_wrap, i_counter_sample};
        cap_secs      = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                div_ctl.start = in_xfer & kind_ok;
            end
            ST_DIV_SEC: begin
                cap_secs = div_sts.done;
            end
            ST_MUL: begin
                // product sits in the top 60 bits so 60 steps leave the quotient low
                div_ctl.start = 1'b1;
                div_ctl.steps = NS_STEPS;
                div_dividend  = {r_prod, {(COUNT_W-PROD_W){1'b0}}};
            end
            ST_DIV_NS: begin
            end
            ST_RESULT: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_err <= ~kind_ok;
            end
        end
    end

    // seconds saturate at 45 bits; remainder scaled to nanoseconds
    always_ff @(posedge i_clk) begin
        if (cap_secs) begin
            r_secs <= (|div_quot[COUNT_W-1:SEC_W]) ? '1 : div_quot[SEC_W-1:0];
            r_prod <= PROD_W'(div_rem) * PROD_W'(NS_PER_SEC);
        end
    end

    // --- output register --------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load_out) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_status      <= r_err ? STATUS_UNSUPPORTED : STATUS_OK;
            o_seconds     <= r_err ? '0 : r_secs;
            o_nanoseconds <= r_err ? '0 : div_quot[NS_W-1:0];
        end
    end

`ifndef NO_ASSERTIONS
    // no request is taken while the divider still works on the last one
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !div_sts.busy)
        else $error("request taken while divider busy");

    // an error result carries zero time
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_UNSUPPORTED) |->
            (o_seconds == '0 && o_nanoseconds == '0))
        else $error("error result with non-zero time");

    // sub-second part always below one second
    a_ns_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_nanoseconds < NS_PER_SEC))
        else $error("nanoseconds out of range");

    // counter extension state moves only on a request transfer
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !in_xfer) |=> ($stable(r_wrap) && $stable(r_prev)))
        else $error("wrap state changed without a transfer");
`endif

endmodule

// ----- verif/cycle_count_to_timespec_unit_tb.sv -----
module cycle_count_to_timespec_unit_tb;

    import cctu_pkg::*;

    // Watchdog: roughly 1.2k requests, their divider runs and the sender gaps between bursts,
    // plus receiver stalls and the long hold-off. Several times over.
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam int unsigned TAIL_CYCLES = 140;
    localparam int unsigned PRINT_CAP   = 20;

    localparam logic [ADDR_W-1:0]  ADDR_CLOCK_HZ = {REG_CLOCK_HZ, 2'b00};
    localparam logic [COUNT_W-1:0] SEC_LIMIT     = (64'd1 << SEC_W) - 64'd1;
    localparam logic [31:0]        HZ_LOW        = 32'd1_000_000;
    localparam logic [31:0]        HZ_HIGH       = 32'd1_000_000_000;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    typedef struct packed {
        logic              status;
        logic [SEC_W-1:0]  seconds;
        logic [NS_W-1:0]   nanoseconds;
    } t_timespec;

    // DUT connections, inputs driven to known values from time zero
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_valid          = 1'b0;
    logic                 o_ready;
    logic [KIND_W-1:0]    i_clock_kind     = KIND_MONOTONIC;
    logic [SAMPLE_W-1:0]  i_counter_sample = '0;
    logic                 o_valid;
    logic                 i_ready          = 1'b0;
    logic                 o_status;
    logic [SEC_W-1:0]     o_seconds;
    logic [NS_W-1:0]      o_nanoseconds;
    logic                 psel             = 1'b0;
    logic                 penable          = 1'b0;
    logic                 pwrite           = 1'b0;
    logic [ADDR_W-1:0]    paddr            = '0;
    logic [DATA_W-1:0]    pwdata           = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // Predictor state: mirrors the block's wrap count, last sample and frequency
    logic [HZ_W-1:0]      hz_model    = HZ_RESET;
    logic [31:0]          wrap_total  = '0;
    logic [SAMPLE_W-1:0]  last_sample = '0;

    // Expected timestamps, oldest first
    t_timespec            timespec_due[$];

    // Sender shaping
    int unsigned          burst_left = 0;
    int unsigned          gap_max    = 0;
    logic [SAMPLE_W-1:0]  sample_cursor = '0;

    // Receiver shaping; hold-off requested by ticket, counted in the receiver itself
    t_rx_mode             rx_mode     = RX_ALWAYS;
    logic [15:0]          rx_pattern  = 16'hFFFF;
    int unsigned          rx_phase    = 0;
    int unsigned          hold_len    = 0;
    int unsigned          hold_ticket = 0;
    int unsigned          hold_seen   = 0;
    int unsigned          hold_left   = 0;

    // Bookkeeping
    int unsigned          cycle_cnt        = 0;
    int unsigned          mismatches       = 0;
    int unsigned          requests_sent    = 0;
    int unsigned          unsupported_sent = 0;
    int unsigned          results_checked  = 0;
    int unsigned          saturated_due    = 0;
    int unsigned          hz_writes        = 0;

    cycle_count_to_timespec_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_clock_kind     (i_clock_kind),
        .i_counter_sample (i_counter_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_seconds        (o_seconds),
        .o_nanoseconds    (o_nanoseconds),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d timestamps outstanding",
                     cycle_cnt, timespec_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
    endtask

    // Timestamp predictor. Unsupported kinds leave wrap count and last sample alone.
    // Frequency 0 divides by 1; seconds clip at the top of its 45-bit range.
    function automatic t_timespec predict_timespec(input logic [KIND_W-1:0] kind,
                                                   input logic [SAMPLE_W-1:0] sample);
        t_timespec          res;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] divisor;
        logic [COUNT_W-1:0] whole;
        logic [COUNT_W-1:0] frac;
        res = '0;
        if (kind != KIND_MONOTONIC && kind != KIND_REALTIME) begin
            res.status = STATUS_UNSUPPORTED;
            return res;
        end
        // equal sample is not a wrap
        if (sample < last_sample)
            wrap_total = wrap_total + 32'd1;
        last_sample = sample;
        count   = {wrap_total, sample};
        divisor = (hz_model == '0) ? 64'd1 : 64'(hz_model);
        whole   = count / divisor;
        // remainder < 2^30 and 1e9 < 2^30, so the product fits in 64 bits
        frac    = ((count % divisor) * 64'(NS_PER_SEC)) / divisor;
        res.status      = STATUS_OK;
        res.seconds     = (whole > SEC_LIMIT) ? SEC_LIMIT[SEC_W-1:0] : whole[SEC_W-1:0];
        res.nanoseconds = frac[NS_W-1:0];
        return res;
    endfunction

    // Result checker: every result transfer is compared with the oldest expectation
    always @(posedge i_clk) begin
        t_timespec want;
        if (i_rst_n && o_valid && i_ready) begin
            if (timespec_due.size() == 0) begin
                report_mismatch("result with nothing outstanding, seconds", o_seconds, 0);
            end else begin
                want = timespec_due.pop_front();
                results_checked++;
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_seconds !== want.seconds)
                    report_mismatch("seconds", o_seconds, want.seconds);
                if (o_nanoseconds !== want.nanoseconds)
                    report_mismatch("nanoseconds", o_nanoseconds, want.nanoseconds);
            end
        end
    end

    // Result receiver: hold-off first, else the current stall mode
    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = hold_len;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    i_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    i_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_ready  <= rx_pattern[rx_phase % 16];
                    rx_phase = rx_phase + 1;
                end
            endcase
        end
    end

    // One request transfer. Bursts of random length, random gaps between bursts.
    // Returns at the edge that accepted the transfer, with valid still high.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [SAMPLE_W-1:0] sample);
        int unsigned gap;
        t_timespec   want;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gap_max != 0)
                gap = $urandom_range(0, gap_max);
        end
        burst_left--;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_clock_kind     <= kind;
        i_counter_sample <= sample;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = predict_timespec(kind, sample);
        timespec_due.push_back(want);
        requests_sent++;
        if (want.status == STATUS_UNSUPPORTED)
            unsupported_sent++;
        else if (want.seconds == SEC_LIMIT[SEC_W-1:0])
            saturated_due++;
    endtask

    // Sender stops offering and waits for every outstanding timestamp.
    // Every request yields a result, so an empty queue means the block is idle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (timespec_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write to clock_hz, then read it straight back. Call only when idle.
    task automatic program_clock_hz(input logic [DATA_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CLOCK_HZ;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // write lands here
        hz_model = word[HZ_W-1:0];
        hz_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== DATA_W'(hz_model))
            report_mismatch("clock_hz readback", prdata, hz_model);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Field extremes, both supported kinds, unsupported kinds, equal samples, wraps
    task automatic test_directed_edges();
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        send_request(KIND_MONOTONIC, 32'h0000_0000);   // equal to reset sample
        send_request(KIND_REALTIME,  32'hFFFF_FFFF);
        send_request(KIND_MONOTONIC, 32'hFFFF_FFFF);   // equal, no wrap
        send_request(2'd2,           32'h0000_0000);   // unsupported, state kept
        send_request(2'd3,           32'h1234_5678);
        send_request(KIND_MONOTONIC, 32'h0000_0005);   // wrap
        send_request(KIND_REALTIME,  32'h8000_0000);
        send_request(KIND_MONOTONIC, 32'h7FFF_FFFF);   // wrap
        send_request(2'd3,           32'hFFFF_FFFF);
        send_request(KIND_REALTIME,  32'h7FFF_FFFF);   // equal after unsupported
        send_request(KIND_MONOTONIC, 32'hAAAA_AAAA);
        send_request(KIND_REALTIME,  32'h5555_5555);   // wrap
        wait_drained();
    endtask

    // Frequency sweep: range ends, zero, one, full field, masked upper bits
    task automatic test_clock_settings();
        logic [DATA_W-1:0] words[8];
        words[0] = HZ_LOW;
        words[1] = HZ_HIGH;
        words[2] = 32'd0;
        words[3] = 32'd1;
        words[4] = 32'h3FFF_FFFF;
        words[5] = 32'hC000_0000 | 32'd25_000_000;
        words[6] = 32'($urandom_range(HZ_LOW, HZ_HIGH));
        words[7] = 32'(HZ_RESET);
        rx_mode = RX_RANDOM;
        foreach (words[w]) begin
            program_clock_hz(words[w]);
            send_request(KIND_MONOTONIC, $urandom);
            send_request(KIND_REALTIME,  $urandom);
            wait_drained();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the result register fills and the request side backs up.
    task automatic test_stalled_receiver();
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        hold_len = 600;
        hold_ticket++;
        repeat (6) begin
            sample_cursor = sample_cursor + 32'($urandom_range(0, 65535));
            send_request(2'($urandom_range(0, 1)), sample_cursor);
        end
        wait_drained();
    endtask

    // Random traffic in phases: fresh frequency, stall mode and gap spread each time.
    // Mostly rising sample streams, with natural wraps; the rest is noise.
    task automatic test_random_traffic();
        logic [SAMPLE_W-1:0] step;
        logic [KIND_W-1:0]   kind;
        logic [DATA_W-1:0]   word;
        repeat (5) begin
            case ($urandom_range(0, 9))
                0:       word = 32'($urandom_range(1, HZ_LOW - 1));        // below range
                1:       word = {2'($urandom_range(0, 3)),
                                 30'($urandom_range(HZ_LOW, HZ_HIGH))};     // junk top bits
                default: word = 32'($urandom_range(HZ_LOW, HZ_HIGH));
            endcase
            program_clock_hz(word);
            rx_mode    = t_rx_mode'($urandom_range(0, 2));
            rx_pattern = 16'($urandom) | 16'h0001;
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 40;
                default: gap_max = 300;
            endcase
            repeat (200) begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        // noise: unsupported kind, any sample
                        send_request(2'($urandom_range(2, 3)), $urandom);
                    end
                    2: begin
                        // broken stream: supported kind, arbitrary jump
                        sample_cursor = $urandom;
                        send_request(2'($urandom_range(0, 1)), sample_cursor);
                    end
                    default: begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: step = 32'($urandom_range(0, 4095));
                            5, 6:          step = 32'($urandom_range(0, 1 << 24));
                            7:             step = $urandom;
                            8:             step = '0;
                            default:       step = -32'($urandom_range(1, 255));
                        endcase
                        sample_cursor = sample_cursor + step;
                        kind          = 2'($urandom_range(0, 1));
                        send_request(kind, sample_cursor);
                    end
                endcase
            end
            wait_drained();
        end
    endtask

    // Zero frequency with a strictly falling sample stream: every request after the first wraps,
    // so the whole extended count lands in the seconds.
    task automatic test_large_counts();
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        program_clock_hz(32'd0);
        sample_cursor = 32'hFFFF_FFFF;
        repeat (150) begin
            send_request(2'($urandom_range(0, 1)), sample_cursor);
            sample_cursor = sample_cursor - 32'($urandom_range(1, 32'h3FFFF));
        end
        wait_drained();
        // large count at small and in-range frequencies
        program_clock_hz(32'd1);
        send_request(KIND_MONOTONIC, sample_cursor);
        send_request(KIND_REALTIME, 32'hFFFF_FFFF);
        wait_drained();
        program_clock_hz(32'd3);
        send_request(KIND_MONOTONIC, 32'hFFFF_FFFF);
        send_request(KIND_REALTIME, $urandom);
        wait_drained();
        program_clock_hz(HZ_LOW);
        rx_mode = RX_RANDOM;
        repeat (4) send_request(2'($urandom_range(0, 3)), $urandom);
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_clock_settings();
        test_stalled_receiver();
        test_random_traffic();
        test_large_counts();

        i_valid <= 1'b0;
        while (timespec_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (timespec_due.size() != 0)
            report_mismatch("timestamps never returned", 0, timespec_due.size());

        $display("covered %0d requests (%0d unsupported kind, %0d clipped seconds)",
                 requests_sent, unsupported_sent, saturated_due);
        $display("checked %0d results over %0d clock_hz writes, %0d mismatches",
                 results_checked, hz_writes, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cctu_pkg.sv
rtl/cctu_div.sv
rtl/cycle_count_to_timespec_unit.sv
verif/cycle_count_to_timespec_unit_tb.sv
